// ===== rtl/core/coherent_bit_demodulator_defines.svh =====
// Assertion macros for the coherent bit demodulator.
`ifndef COHERENT_BIT_DEMODULATOR_DEFINES_SVH
`define COHERENT_BIT_DEMODULATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define COH_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("coherent_bit_demodulator: assertion failed");
`define COH_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("coherent_bit_demodulator: assertion failed");
`else
`define COH_ASSERT_IMP(label, clk, rst, ante, cons)
`define COH_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/coh_pkg.sv =====
package coh_pkg;

   localparam int SPB_W       = 13;
   localparam int SUM_W       = 48;
   localparam int STEP_W      = 32;
   localparam int PHASE_W     = 32;
   localparam int OFFSET_W    = 16;
   localparam int GAIN_W      = 4;
   localparam int SINE_W      = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 48;

   localparam logic [63:0] ONE_Q30     = 64'd1073741824;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] SINE_MAX    = 64'd32767;

   localparam logic [SPB_W-1:0]  SPB_RESET  = 13'd500;
   localparam logic [STEP_W-1:0] STEP1_RESET = 32'd8589935;
   localparam logic [STEP_W-1:0] STEP2_RESET = 32'd17179869;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 4'd8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FSK_MODE  = 3'd0,
      CSR_THRESHOLD = 3'd1,
      CSR_SPB       = 3'd2,
      CSR_STEP1     = 3'd3,
      CSR_STEP2     = 3'd4,
      CSR_OFFSET    = 3'd5,
      CSR_GAIN      = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic                    fsk_mode;
      logic signed [SUM_W-1:0] decision_threshold;
      logic [SPB_W-1:0]        samples_per_bit;
      logic [STEP_W-1:0]       carrier_step_first;
      logic [STEP_W-1:0]       carrier_step_second;
      logic [OFFSET_W-1:0]     carrier_phase_offset;
      logic [GAIN_W-1:0]       carrier_gain;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE    = 3'd0,
      ST_LOOKUP  = 3'd1,
      ST_CARRIER = 3'd2,
      ST_PRODUCT = 3'd3,
      ST_ACCUM   = 3'd4,
      ST_VALUE   = 3'd5,
      ST_DECIDE  = 3'd6
   } state_type;

   typedef struct packed {
      logic take_sample;
      logic lookup;
      logic carrier;
      logic product;
      logic accum;
      logic value;
      logic load_out;
   } cmd_type;

   // Quarter-wave sine in Q15, evaluated at elaboration for the table.
   function automatic logic [SINE_W-2:0] quarter_sine(input logic [63:0] m,
                                                      input int unsigned quarter_bits);
      logic [63:0] x, x2, a, b, c, d, s, v;
      x  = (m * HALF_PI_Q30) >> quarter_bits;
      x2 = (x * x) >> 30;
      a  = ONE_Q30 - x2 / 72;
      b  = ONE_Q30 - ((x2 * a) >> 30) / 42;
      c  = ONE_Q30 - ((x2 * b) >> 30) / 20;
      d  = ONE_Q30 - ((x2 * c) >> 30) / 6;
      s  = (x * d) >> 30;
      v  = (s * SINE_MAX + (64'd1 << 29)) >> 30;
      if (v > SINE_MAX) begin
         v = SINE_MAX;
      end
      return v[SINE_W-2:0];
   endfunction

   function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W:0] v);
      logic [SUM_W-1:0] r;
      if (v[SUM_W] != v[SUM_W-1]) begin
         r = {v[SUM_W], {(SUM_W-1){~v[SUM_W]}}};
      end else begin
         r = v[SUM_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/coh_ctrl.sv =====
module coh_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output coh_pkg::cmd_type cmd
);

   coh_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= coh_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      req_ready    = 1'b0;
      unique case (state_ff)
         coh_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take_sample = 1'b1;
               state_in        = coh_pkg::ST_LOOKUP;
            end
         end
         coh_pkg::ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = coh_pkg::ST_CARRIER;
         end
         coh_pkg::ST_CARRIER: begin
            cmd.carrier = 1'b1;
            state_in    = coh_pkg::ST_PRODUCT;
         end
         coh_pkg::ST_PRODUCT: begin
            cmd.product = 1'b1;
            state_in    = coh_pkg::ST_ACCUM;
         end
         coh_pkg::ST_ACCUM: begin
            cmd.accum = 1'b1;
            state_in  = coh_pkg::ST_VALUE;
         end
         coh_pkg::ST_VALUE: begin
            cmd.value = 1'b1;
            state_in  = coh_pkg::ST_DECIDE;
         end
         coh_pkg::ST_DECIDE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = coh_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = coh_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/core/coh_dp.sv =====
module coh_dp #(
   parameter int SAMPLE_BITS     = 16,
   parameter int SINE_INDEX_BITS = 10,
   parameter int MAX_WINDOW      = 4096
) (
   input  logic                             clock,
   input  logic                             reset,
   input  coh_pkg::cmd_type                 cmd,
   input  coh_pkg::cfg_type                 cfg,
   input  logic signed [SAMPLE_BITS-1:0]    req_rx_sample,
   output logic signed [coh_pkg::SUM_W-1:0] rsp_running_integral,
   output logic                             rsp_bit_decision,
   output logic                             rsp_bit_end
);

   localparam int QB      = SINE_INDEX_BITS - 2;
   localparam int QUARTER = 1 << QB;
   localparam int SINE_W  = coh_pkg::SINE_W;
   localparam int SUM_W   = coh_pkg::SUM_W;
   localparam int PHASE_W = coh_pkg::PHASE_W;
   localparam int CAR_W   = SINE_W + coh_pkg::GAIN_W;
   localparam int PROD_W  = SAMPLE_BITS + CAR_W;
   localparam int WC_W    = $clog2(MAX_WINDOW);
   localparam int LEN_W   = $clog2(MAX_WINDOW + 1);
   localparam int CMP_W   = (coh_pkg::SPB_W > LEN_W) ? coh_pkg::SPB_W : LEN_W;
   localparam logic [QB:0]      QUARTER_M = {1'b1, {QB{1'b0}}};
   localparam logic [CMP_W-1:0] MAX_LEN   = CMP_W'(MAX_WINDOW);
   localparam logic [CMP_W-1:0] ONE_LEN   = CMP_W'(1);

   logic [SINE_W-2:0] quarter_rom [QUARTER+1];

   for (genvar g = 0; g <= QUARTER; g++) begin : g_rom
      assign quarter_rom[g] = coh_pkg::quarter_sine(64'(g), QB);
   end

   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic signed [SINE_W-1:0]      sine1_ff, sine1_in, sine2_ff, sine2_in;
   logic signed [CAR_W-1:0]       car1_ff, car1_in, car2_ff, car2_in;
   logic signed [CAR_W:0]         car1_full, car2_full;
   logic signed [PROD_W-1:0]      prod1_ff, prod2_ff;
   logic signed [SUM_W-1:0]       sum1_ff, sum1_in, sum2_ff, sum2_in;
   logic signed [SUM_W-1:0]       base1, base2, value_ff, value_in;
   logic [PHASE_W-1:0]            phase1_ff, phase1_in, phase2_ff, phase2_in;
   logic [PHASE_W-1:0]            p1, p2;
   logic [SINE_INDEX_BITS-1:0]    idx1, idx2;
   logic [QB:0]                   m1, m2;
   logic [WC_W-1:0]               count_ff, count_in;
   logic                          last_ff, last_in;
   logic [CMP_W-1:0]              spb_ext, len;
   logic signed [SUM_W-1:0]       rsp_int_ff;
   logic                          rsp_dec_ff, rsp_dec_in, rsp_end_ff;

   // Carrier phase to quarter-table address and signed sine value
   always_comb begin
      p1   = phase1_ff + {cfg.carrier_phase_offset, {(PHASE_W-coh_pkg::OFFSET_W){1'b0}}};
      p2   = phase2_ff + {cfg.carrier_phase_offset, {(PHASE_W-coh_pkg::OFFSET_W){1'b0}}};
      idx1 = p1[PHASE_W-1 -: SINE_INDEX_BITS];
      idx2 = p2[PHASE_W-1 -: SINE_INDEX_BITS];
      m1   = idx1[QB] ? (QUARTER_M - {1'b0, idx1[QB-1:0]}) : {1'b0, idx1[QB-1:0]};
      m2   = idx2[QB] ? (QUARTER_M - {1'b0, idx2[QB-1:0]}) : {1'b0, idx2[QB-1:0]};
      sine1_in = idx1[QB+1] ? -$signed({1'b0, quarter_rom[m1]})
                            :  $signed({1'b0, quarter_rom[m1]});
      sine2_in = idx2[QB+1] ? -$signed({1'b0, quarter_rom[m2]})
                            :  $signed({1'b0, quarter_rom[m2]});
   end

   always_comb begin
      car1_full = $signed({1'b0, cfg.carrier_gain}) * sine1_ff;
      car2_full = $signed({1'b0, cfg.carrier_gain}) * sine2_ff;
      car1_in   = car1_full[CAR_W-1:0];
      car2_in   = car2_full[CAR_W-1:0];
   end

   // Window length, clamped to 1..MAX_WINDOW, and the next window position
   always_comb begin
      spb_ext = CMP_W'(cfg.samples_per_bit);
      if (spb_ext == '0) begin
         len = ONE_LEN;
      end else if (spb_ext > MAX_LEN) begin
         len = MAX_LEN;
      end else begin
         len = spb_ext;
      end
      last_in  = CMP_W'(count_ff) >= (len - ONE_LEN);
      count_in = last_in ? '0 : count_ff + WC_W'(1);
   end

   always_comb begin
      base1     = (count_ff == '0) ? '0 : sum1_ff;
      base2     = (count_ff == '0) ? '0 : sum2_ff;
      sum1_in   = coh_pkg::sat_sum($signed({base1[SUM_W-1], base1}) + (SUM_W+1)'(prod1_ff));
      sum2_in   = coh_pkg::sat_sum($signed({base2[SUM_W-1], base2}) + (SUM_W+1)'(prod2_ff));
      phase1_in = phase1_ff + cfg.carrier_step_first;
      phase2_in = phase2_ff + cfg.carrier_step_second;
   end

   always_comb begin
      if (cfg.fsk_mode) begin
         value_in = coh_pkg::sat_sum($signed({sum2_ff[SUM_W-1], sum2_ff})
                                     - $signed({sum1_ff[SUM_W-1], sum1_ff}));
      end else begin
         value_in = sum1_ff;
      end
      rsp_dec_in = !(value_ff > cfg.decision_threshold);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase1_ff <= '0;
         phase2_ff <= '0;
         sum1_ff   <= '0;
         sum2_ff   <= '0;
         count_ff  <= '0;
      end else if (cmd.accum) begin
         phase1_ff <= phase1_in;
         phase2_ff <= phase2_in;
         sum1_ff   <= sum1_in;
         sum2_ff   <= sum2_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_sample) begin
         sample_ff <= req_rx_sample;
      end
      if (cmd.lookup) begin
         sine1_ff <= sine1_in;
         sine2_ff <= sine2_in;
      end
      if (cmd.carrier) begin
         car1_ff <= car1_in;
         car2_ff <= car2_in;
      end
      if (cmd.product) begin
         prod1_ff <= sample_ff * car1_ff;
         prod2_ff <= sample_ff * car2_ff;
      end
      if (cmd.accum) begin
         last_ff <= last_in;
      end
      if (cmd.value) begin
         value_ff <= value_in;
      end
      if (cmd.load_out) begin
         rsp_int_ff <= value_ff;
         rsp_dec_ff <= rsp_dec_in;
         rsp_end_ff <= last_ff;
      end
   end

   assign rsp_running_integral = rsp_int_ff;
   assign rsp_bit_decision     = rsp_dec_ff;
   assign rsp_bit_end          = rsp_end_ff;

endmodule

// ===== rtl/core/coherent_bit_demodulator.sv =====
// A result is offered after the controller's walk through lookup, carrier
// scale, product, accumulate, difference and decision steps; no new request is
// taken until the walk ends, and decision waits while an old result is not taken.
// Reset (synchronous, active high) clears phases, sums, window count and
// handshake state, and loads the configuration registers with their defaults.
`include "coherent_bit_demodulator_defines.svh"

module coherent_bit_demodulator #(
   parameter int SAMPLE_BITS     = 16,
   parameter int SINE_INDEX_BITS = 10,
   parameter int MAX_WINDOW      = 4096
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [SAMPLE_BITS-1:0]          req_rx_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [coh_pkg::SUM_W-1:0]       rsp_running_integral,
   output logic                                   rsp_bit_decision,
   output logic                                   rsp_bit_end,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [coh_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [coh_pkg::CSR_DATA_W-1:0]         csr_data
);

   coh_pkg::cfg_type cfg_ff, cfg_in;
   coh_pkg::cmd_type cmd;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (coh_pkg::csr_index_type'(csr_index))
            coh_pkg::CSR_FSK_MODE:  cfg_in.fsk_mode             = csr_data[0];
            coh_pkg::CSR_THRESHOLD: cfg_in.decision_threshold   = csr_data[coh_pkg::SUM_W-1:0];
            coh_pkg::CSR_SPB:       cfg_in.samples_per_bit      = csr_data[coh_pkg::SPB_W-1:0];
            coh_pkg::CSR_STEP1:     cfg_in.carrier_step_first   = csr_data[coh_pkg::STEP_W-1:0];
            coh_pkg::CSR_STEP2:     cfg_in.carrier_step_second  = csr_data[coh_pkg::STEP_W-1:0];
            coh_pkg::CSR_OFFSET:    cfg_in.carrier_phase_offset = csr_data[coh_pkg::OFFSET_W-1:0];
            coh_pkg::CSR_GAIN:      cfg_in.carrier_gain         = csr_data[coh_pkg::GAIN_W-1:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fsk_mode             <= 1'b0;
         cfg_ff.decision_threshold   <= '0;
         cfg_ff.samples_per_bit      <= coh_pkg::SPB_RESET;
         cfg_ff.carrier_step_first   <= coh_pkg::STEP1_RESET;
         cfg_ff.carrier_step_second  <= coh_pkg::STEP2_RESET;
         cfg_ff.carrier_phase_offset <= '0;
         cfg_ff.carrier_gain         <= coh_pkg::GAIN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   coh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   coh_dp #(
      .SAMPLE_BITS     (SAMPLE_BITS),
      .SINE_INDEX_BITS (SINE_INDEX_BITS),
      .MAX_WINDOW      (MAX_WINDOW)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .cfg                  (cfg_ff),
      .req_rx_sample        (req_rx_sample),
      .rsp_running_integral (rsp_running_integral),
      .rsp_bit_decision     (rsp_bit_decision),
      .rsp_bit_end          (rsp_bit_end)
   );

   `COH_ASSERT_NXT(a_one_request, clock, reset, req_valid && req_ready, !req_ready)
   `COH_ASSERT_NXT(a_load_shows, clock, reset, cmd.load_out, rsp_valid)
   `COH_ASSERT_IMP(a_decision, clock, reset, rsp_valid, rsp_bit_decision == !(rsp_running_integral > cfg_ff.decision_threshold))

endmodule

// ===== tb/coherent_bit_demodulator_checker.sv =====
`timescale 1ns / 1ps

module coherent_bit_demodulator_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic signed [15:0]               req_rx_sample,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic signed [coh_pkg::SUM_W-1:0] rsp_running_integral,
   input  logic                             rsp_bit_decision,
   input  logic                             rsp_bit_end,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [coh_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [coh_pkg::CSR_DATA_W-1:0]   csr_data,
   output int                               outstanding,
   output int                               mismatches
);

   localparam longint SUM_HI = (longint'(1) <<< 47) - 1;
   localparam longint SUM_LO = -(longint'(1) <<< 47);
   localparam int QUARTER = 256;
   localparam int WINDOW_MAX = 4096;

   typedef struct {
      logic [coh_pkg::SUM_W-1:0] integral;
      logic                      decision;
      logic                      bit_last;
   } demod_result_type;

   demod_result_type   predicted_results[$];
   demod_result_type   oldest;
   coh_pkg::cfg_type   regs;
   logic signed [15:0] quarter_table [0:QUARTER];
   logic [31:0]        phase_a;
   logic [31:0]        phase_b;
   int unsigned        position;
   longint             acc_a;
   longint             acc_b;

   // Q30 polynomial sine over the first quadrant, truncating at each step but the last, which rounds to Q15
   function automatic logic signed [15:0] quarter_wave(input int m);
      logic [63:0] ang, sq, t1, t2, t3, t4, y, q15;
      ang = (64'(m) * 64'd1686629713) / 64'(QUARTER);
      sq  = (ang * ang) >> 30;
      t1  = 64'd1073741824 - sq / 64'd72;
      t2  = 64'd1073741824 - ((sq * t1) >> 30) / 64'd42;
      t3  = 64'd1073741824 - ((sq * t2) >> 30) / 64'd20;
      t4  = 64'd1073741824 - ((sq * t3) >> 30) / 64'd6;
      y   = (ang * t4) >> 30;
      q15 = (y * 64'd32767 + (64'd1 << 29)) >> 30;
      if (q15 > 64'd32767) begin
         q15 = 64'd32767;
      end
      return q15[15:0];
   endfunction

   function automatic longint clamp48(input longint v);
      if (v > SUM_HI) begin
         return SUM_HI;
      end
      if (v < SUM_LO) begin
         return SUM_LO;
      end
      return v;
   endfunction

   function automatic longint carrier_at(input logic [31:0] phase);
      logic [31:0] p;
      logic [9:0]  idx;
      int          m;
      longint      v;
      p   = phase + {regs.carrier_phase_offset, 16'h0000};
      idx = p[31:22];
      m   = idx[8] ? QUARTER - int'(idx[7:0]) : int'(idx[7:0]);
      v   = longint'(quarter_table[m]);
      if (idx[9]) begin
         v = -v;
      end
      return v * longint'(regs.carrier_gain);
   endfunction

   function automatic void correlate_sample(input logic signed [15:0] rx);
      longint           c1, c2, val, limit;
      int unsigned      len;
      logic             ends_bit;
      demod_result_type res;
      len = regs.samples_per_bit;
      if (len < 1) begin
         len = 1;
      end
      if (len > WINDOW_MAX) begin
         len = WINDOW_MAX;
      end
      c1 = carrier_at(phase_a);
      c2 = carrier_at(phase_b);
      if (position == 0) begin
         acc_a = 0;
         acc_b = 0;
      end
      acc_a = clamp48(acc_a + longint'(rx) * c1);
      acc_b = clamp48(acc_b + longint'(rx) * c2);
      phase_a = phase_a + regs.carrier_step_first;
      phase_b = phase_b + regs.carrier_step_second;
      ends_bit = (position >= len - 1);
      position = ends_bit ? 0 : position + 1;
      val = regs.fsk_mode ? clamp48(acc_b - acc_a) : acc_a;
      limit = longint'(regs.decision_threshold);
      res.integral = val[coh_pkg::SUM_W-1:0];
      res.decision = (val > limit) ? 1'b0 : 1'b1;
      res.bit_last = ends_bit;
      predicted_results = {predicted_results, res};
   endfunction

   initial begin
      for (int m = 0; m <= QUARTER; m++) begin
         quarter_table[m] = quarter_wave(m);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         regs.fsk_mode             = 1'b0;
         regs.decision_threshold   = '0;
         regs.samples_per_bit      = coh_pkg::SPB_RESET;
         regs.carrier_step_first   = coh_pkg::STEP1_RESET;
         regs.carrier_step_second  = coh_pkg::STEP2_RESET;
         regs.carrier_phase_offset = '0;
         regs.carrier_gain         = coh_pkg::GAIN_RESET;
         phase_a  = '0;
         phase_b  = '0;
         position = 0;
         acc_a    = 0;
         acc_b    = 0;
         predicted_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (coh_pkg::csr_index_type'(csr_index))
               coh_pkg::CSR_FSK_MODE:
                  regs.fsk_mode = csr_data[0];
               coh_pkg::CSR_THRESHOLD:
                  regs.decision_threshold = csr_data[coh_pkg::SUM_W-1:0];
               coh_pkg::CSR_SPB:
                  regs.samples_per_bit = csr_data[coh_pkg::SPB_W-1:0];
               coh_pkg::CSR_STEP1:
                  regs.carrier_step_first = csr_data[coh_pkg::STEP_W-1:0];
               coh_pkg::CSR_STEP2:
                  regs.carrier_step_second = csr_data[coh_pkg::STEP_W-1:0];
               coh_pkg::CSR_OFFSET:
                  regs.carrier_phase_offset = csr_data[coh_pkg::OFFSET_W-1:0];
               coh_pkg::CSR_GAIN:
                  regs.carrier_gain = csr_data[coh_pkg::GAIN_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            correlate_sample(req_rx_sample);
         end
         if (rsp_valid && rsp_ready) begin
            if (predicted_results.size() == 0) begin
               $error("result with no request outstanding: integral %0d",
                      rsp_running_integral);
               mismatches++;
            end else begin
               oldest = predicted_results.pop_front();
               if (rsp_running_integral !== oldest.integral) begin
                  $error("running_integral: expected %0d, got %0d",
                         $signed(oldest.integral), rsp_running_integral);
                  mismatches++;
               end
               if (rsp_bit_decision !== oldest.decision) begin
                  $error("bit_decision: expected %0b, got %0b",
                         oldest.decision, rsp_bit_decision);
                  mismatches++;
               end
               if (rsp_bit_end !== oldest.bit_last) begin
                  $error("bit_end: expected %0b, got %0b", oldest.bit_last, rsp_bit_end);
                  mismatches++;
               end
            end
         end
      end
      outstanding <= predicted_results.size();
   end

endmodule

// ===== tb/coherent_bit_demodulator_tb.sv =====
`timescale 1ns / 1ps

module coherent_bit_demodulator_tb;

   localparam int STALL_LIMIT       = 3000;
   localparam int RANDOM_PHASES     = 20;
   localparam int SAMPLES_PER_PHASE = 55;
   localparam int HOLD_AFTER        = 300;
   localparam int HOLD_CYCLES       = 300;

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_ready;
   logic signed [15:0]               req_rx_sample;
   logic                             rsp_valid;
   logic                             rsp_ready;
   logic signed [coh_pkg::SUM_W-1:0] rsp_running_integral;
   logic                             rsp_bit_decision;
   logic                             rsp_bit_end;
   logic                             csr_valid;
   logic                             csr_ready;
   logic [coh_pkg::CSR_INDEX_W-1:0]  csr_index;
   logic [coh_pkg::CSR_DATA_W-1:0]   csr_data;
   int                               outstanding;
   int                               mismatches;
   int                               send_idle_pct;
   int                               recv_idle_pct;

   coherent_bit_demodulator dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_rx_sample        (req_rx_sample),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_running_integral (rsp_running_integral),
      .rsp_bit_decision     (rsp_bit_decision),
      .rsp_bit_end          (rsp_bit_end),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   coherent_bit_demodulator_checker demod_check (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_rx_sample        (req_rx_sample),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_running_integral (rsp_running_integral),
      .rsp_bit_decision     (rsp_bit_decision),
      .rsp_bit_end          (rsp_bit_end),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .outstanding          (outstanding),
      .mismatches           (mismatches)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic write_reg(input coh_pkg::csr_index_type idx,
                            input logic [coh_pkg::CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic fsk, input logic [47:0] thr, input logic [12:0] spb,
                            input logic [31:0] step1, input logic [31:0] step2,
                            input logic [15:0] offset, input logic [3:0] gain);
      write_reg(coh_pkg::CSR_FSK_MODE, fsk);
      write_reg(coh_pkg::CSR_THRESHOLD, thr);
      write_reg(coh_pkg::CSR_SPB, spb);
      write_reg(coh_pkg::CSR_STEP1, step1);
      write_reg(coh_pkg::CSR_STEP2, step2);
      write_reg(coh_pkg::CSR_OFFSET, offset);
      write_reg(coh_pkg::CSR_GAIN, gain);
   endtask

   task automatic send_sample(input logic signed [15:0] rx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_rx_sample <= rx;
      do @(posedge clock); while (!req_ready);
   endtask

   // drop valid and wait for every outstanding result
   task automatic finish_burst();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   function automatic logic signed [15:0] pick_sample();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(7))
         0: return 16'sh7FFF;
         1: return -16'sh8000;
         2: return 16'($urandom_range(63)) - 16'sd32;
         default: return r[15:0];
      endcase
   endfunction

   function automatic logic [47:0] pick_threshold();
      logic [63:0] r;
      r = {$urandom, $urandom};
      case ($urandom_range(5))
         0: return 48'h7FFF_FFFF_FFFF;
         1: return 48'h8000_0000_0000;
         2: return 48'h0;
         3: return r[47:0];
         default: return {{12{r[35]}}, r[35:0]};
      endcase
   endfunction

   // mostly short windows so that bits complete often
   function automatic logic [12:0] pick_window();
      case ($urandom_range(9))
         0: return 13'd0;
         1: return 13'd1;
         2: return 13'd8191;
         3: return 13'd4096;
         4: return 13'($urandom_range(8190, 4097));
         default: return 13'($urandom_range(40, 2));
      endcase
   endfunction

   function automatic logic [31:0] pick_step();
      case ($urandom_range(5))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         2: return 32'($urandom_range(32'h0100_0000, 1));
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [15:0] pick_offset();
      case ($urandom_range(5))
         0: return 16'h0000;
         1: return 16'h8000;
         2: return 16'hFFFF;
         default: return 16'($urandom_range(65535));
      endcase
   endfunction

   function automatic logic [3:0] pick_gain();
      case ($urandom_range(5))
         0: return 4'd0;
         1: return 4'd15;
         default: return 4'($urandom_range(15, 1));
      endcase
   endfunction

   // receiver: random stalls, plus one long hold-off to back the block up
   initial begin
      int  taken;
      int  hold_left;
      bit  hold_fired;
      taken      = 0;
      hold_left  = 0;
      hold_fired = 1'b0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            taken++;
         end
         if (taken >= HOLD_AFTER && !hold_fired) begin
            hold_fired = 1'b1;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("coherent_bit_demodulator: mismatch");
      $finish;
   end

   initial begin
      int p;
      int i;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_rx_sample <= '0;
      csr_valid     <= 1'b0;
      csr_index     <= '0;
      csr_data      <= '0;
      send_idle_pct = 28;
      recv_idle_pct = 86;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset configuration, sample extremes
      send_sample(16'sh7FFF);
      send_sample(-16'sh8000);
      send_sample(16'sh0000);
      send_sample(-16'sh0001);
      send_sample(16'sh0001);
      send_sample(16'sh5555);
      send_sample(-16'sh5556);
      finish_burst();

      // zero window acts as one sample per bit
      configure(1'b0, 48'h0, 13'd0, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 4'd15);
      send_sample(16'sh7FFF);
      send_sample(-16'sh8000);
      send_sample(16'sd12345);
      finish_burst();

      // FSK, top threshold, then window cut short mid-bit
      configure(1'b1, 48'h7FFF_FFFF_FFFF, 13'd10, 32'h4000_0000, 32'h1234_5678,
                16'h8000, 4'd1);
      for (i = 0; i < 7; i++) begin
         send_sample(pick_sample());
      end
      finish_burst();
      write_reg(coh_pkg::CSR_SPB, 13'd4);
      send_sample(-16'sh8000);
      send_sample(16'sh7FFF);
      finish_burst();

      // gain zero, bottom threshold
      configure(1'b0, 48'h8000_0000_0000, 13'd3, 32'h0, 32'h8000_0000, 16'h4000, 4'd0);
      send_sample(16'sh7FFF);
      send_sample(-16'sh8000);
      send_sample(16'sh1234);
      finish_burst();

      // window beyond the maximum
      write_reg(coh_pkg::CSR_SPB, 13'd8191);
      send_sample(16'sh7FFF);
      send_sample(-16'sh8000);
      send_sample(-16'sh0001);
      finish_burst();

      for (p = 0; p < RANDOM_PHASES; p++) begin
         if (p == 7) begin
            send_idle_pct = 86;
            recv_idle_pct = 28;
         end
         if (p == 14) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         configure(1'($urandom_range(1)), pick_threshold(), pick_window(), pick_step(),
                   pick_step(), pick_offset(), pick_gain());
         for (i = 0; i < SAMPLES_PER_PHASE; i++) begin
            send_sample(pick_sample());
         end
         finish_burst();
      end

      repeat (12) @(posedge clock);
      if (mismatches == 0) begin
         $display("coherent_bit_demodulator: match");
      end else begin
         $display("coherent_bit_demodulator: mismatch");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/coh_pkg.sv
rtl/core/coh_ctrl.sv
rtl/core/coh_dp.sv
rtl/core/coherent_bit_demodulator.sv
tb/coherent_bit_demodulator_checker.sv
tb/coherent_bit_demodulator_tb.sv
